// ----- rtl/irt_pkg.sv -----
// shared constants, types and codes of the io region translation table
package irt_pkg;

    // table geometry and field widths
    localparam int ENTRIES   = 64;
    localparam int ADDR_BITS = 48;
    localparam int LEN_BITS  = 32;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (ADDR_BITS > LEN_BITS) ? ADDR_BITS : LEN_BITS;
    localparam int OP_W  = 3;
    localparam int STS_W = 2;

    // operation codes of a request
    typedef enum logic [OP_W-1:0] {
        OP_MAP          = 3'd0,
        OP_UNMAP        = 3'd1,
        OP_VIRT_TO_PHYS = 3'd2,
        OP_PHYS_TO_VIRT = 3'd3,
        OP_IS_MAPPED    = 3'd4,
        OP_UNMAP_ALL    = 3'd5
    } op_t;

    // result status codes
    typedef enum logic [STS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_NULL_BASE = 2'd3
    } status_t;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } state_t;

    // one table entry as held in the memory
    typedef struct packed {
        logic [ADDR_BITS-1:0] virt;
        logic [ADDR_BITS-1:0] phys;
        logic [LEN_BITS-1:0]  len;
    } entry_t;

endpackage

// ----- rtl/irt_req_if.sv -----
// request channel of the io region translation table
interface irt_req_if;
    import irt_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      operation;
    logic [ADDR_BITS-1:0] virt_addr;
    logic [ADDR_BITS-1:0] phys_addr;
    logic [LEN_BITS-1:0]  length;

    modport source (output valid, output operation, output virt_addr,
                    output phys_addr, output length, input ready);
    modport sink   (input valid, input operation, input virt_addr,
                    input phys_addr, input length, output ready);
endinterface

// ----- rtl/irt_rsp_if.sv -----
// result channel of the io region translation table
interface irt_rsp_if;
    import irt_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [STS_W-1:0]     status;
    logic [ADDR_BITS-1:0] addr_out;
    logic [LEN_BITS-1:0]  length_out;
    logic                 hit;
    logic                 last;

    modport source (output valid, output status, output addr_out,
                    output length_out, output hit, output last, input ready);
    modport sink   (input valid, input status, input addr_out,
                    input length_out, input hit, input last, output ready);
endinterface

// ----- rtl/io_region_translation_table.sv -----
// top level of the io region translation table: entry memory and scan sequencer
//
// The table keeps ENTRIES regions (virtual base, physical base, length) in one
// synchronous memory with a registered read port, and a valid bit per slot in
// flip-flops that reset clears. Every operation walks the slots in index order,
// one memory read per cycle while the result register is free or being taken,
// and, unmap-all apart, stops at the first slot that decides it: the lowest
// free slot for map, the lowest exact virtual base for unmap, and the lowest
// valid region that contains the address for the translations and the
// is-mapped test. A request is accepted in S_IDLE, walked in S_SCAN through
// the read and check registers, and a translation then adds base and offset
// in S_FIN; a deciding slot that comes early ends the walk sooner. The single
// read port sets the pace of the walk. Unmap-all emits one result per valid
// region in slot order and the walk holds whenever the result register is
// still occupied; the table is empty once its last result is produced. A new
// request is taken while an earlier result still waits in the output register.
// Operation codes 6 and 7 are accepted and dropped without a result.
module io_region_translation_table (
    input  logic          clk,
    input  logic          rst_n,
    irt_req_if.sink       req,
    irt_rsp_if.source     rsp
);
    import irt_pkg::*;

    // sequencer and request registers
    state_t               state_reg, state_next;
    op_t                  op_reg;
    logic [ADDR_BITS-1:0] va_reg;
    logic [ADDR_BITS-1:0] pa_reg;
    logic [LEN_BITS-1:0]  len_reg;

    // scan pipeline
    logic [CNT_W-1:0]     rd_idx_reg;
    logic                 chk_pend_reg;
    logic                 chk_valid_reg;
    logic [IDX_W-1:0]     chk_idx_reg;
    entry_t               rdata_reg;

    // translation add stage
    logic [ADDR_BITS-1:0] base_reg;
    logic [ADDR_BITS-1:0] off_reg;

    // slot state
    logic [ENTRIES-1:0]   valid_reg;
    entry_t               mem [ENTRIES];

    // result register
    logic                 out_valid_reg;
    status_t              status_reg;
    logic [ADDR_BITS-1:0] addr_out_reg;
    logic [LEN_BITS-1:0]  length_out_reg;
    logic                 hit_reg;
    logic                 last_reg;

    // control
    logic                 req_acc;
    logic                 op_known;
    logic                 adv;
    logic                 scan_done;
    logic                 rd_en;
    logic                 entry_hit;
    logic                 scan_stop;
    logic                 cap_fin;
    logic                 mem_we;
    logic                 set_v;
    logic                 clr_v;
    logic                 out_load;
    status_t              status_n;
    logic [ADDR_BITS-1:0] addr_n;
    logic [LEN_BITS-1:0]  len_n;
    logic                 hit_n;
    logic                 last_n;

    // containment test against the entry under check
    logic                 by_phys;
    logic [ADDR_BITS-1:0] key;
    logic [ADDR_BITS-1:0] key_base;
    logic [ADDR_BITS-1:0] other_base;
    logic [ADDR_BITS:0]   dsub;
    logic                 in_range;
    logic [ENTRIES-1:0]   rest_valid;
    logic                 none_left;

    // handshake
    assign req.ready = (state_reg == S_IDLE);
    assign req_acc   = req.valid && req.ready;
    assign op_known  = (req.operation <= OP_W'(OP_UNMAP_ALL));
    assign adv       = !out_valid_reg || rsp.ready;
    assign scan_done = (rd_idx_reg == CNT_W'(ENTRIES));

    // region containment: base <= key and key - base < length
    assign by_phys    = (op_reg == OP_PHYS_TO_VIRT) || (op_reg == OP_IS_MAPPED);
    assign key        = by_phys ? pa_reg : va_reg;
    assign key_base   = by_phys ? rdata_reg.phys : rdata_reg.virt;
    assign other_base = by_phys ? rdata_reg.virt : rdata_reg.phys;
    assign dsub       = {1'b0, key} - {1'b0, key_base};
    assign in_range   = !dsub[ADDR_BITS] &&
                        (CMP_W'(dsub[ADDR_BITS-1:0]) < CMP_W'(rdata_reg.len));

    // valid slots left once the one under check is released
    assign rest_valid = valid_reg & ~(ENTRIES'(1) << chk_idx_reg);
    assign none_left  = (rest_valid == '0);

    // slot decision per operation
    always_comb
    begin
        case (op_reg)
            OP_MAP:          entry_hit = !chk_valid_reg;
            OP_UNMAP:        entry_hit = chk_valid_reg && (rdata_reg.virt == va_reg);
            OP_VIRT_TO_PHYS,
            OP_PHYS_TO_VIRT,
            OP_IS_MAPPED:    entry_hit = chk_valid_reg && in_range;
            OP_UNMAP_ALL:    entry_hit = chk_valid_reg;
            default:         entry_hit = 1'b0;
        endcase
    end

    // scan control and result formation
    always_comb
    begin
        rd_en     = 1'b0;
        scan_stop = 1'b0;
        cap_fin   = 1'b0;
        mem_we    = 1'b0;
        set_v     = 1'b0;
        clr_v     = 1'b0;
        out_load  = 1'b0;
        status_n  = ST_OK;
        addr_n    = '0;
        len_n     = '0;
        hit_n     = 1'b0;
        last_n    = 1'b1;
        if (state_reg == S_SCAN && adv)
        begin
            rd_en = !scan_done;
            if (chk_pend_reg && entry_hit)
            begin
                case (op_reg)
                    OP_MAP:
                    begin
                        scan_stop = 1'b1;
                        out_load  = 1'b1;
                        if (va_reg == '0)
                        begin
                            status_n = ST_NULL_BASE;
                        end
                        else
                        begin
                            mem_we = 1'b1;
                            set_v  = 1'b1;
                            addr_n = va_reg;
                        end
                    end
                    OP_UNMAP:
                    begin
                        scan_stop = 1'b1;
                        out_load  = 1'b1;
                        clr_v     = 1'b1;
                        addr_n    = rdata_reg.virt;
                        len_n     = rdata_reg.len;
                    end
                    OP_VIRT_TO_PHYS,
                    OP_PHYS_TO_VIRT:
                    begin
                        scan_stop = 1'b1;
                        cap_fin   = 1'b1;
                    end
                    OP_IS_MAPPED:
                    begin
                        scan_stop = 1'b1;
                        out_load  = 1'b1;
                        hit_n     = 1'b1;
                    end
                    OP_UNMAP_ALL:
                    begin
                        scan_stop = none_left;
                        out_load  = 1'b1;
                        clr_v     = 1'b1;
                        addr_n    = rdata_reg.virt;
                        len_n     = rdata_reg.len;
                        last_n    = none_left;
                    end
                    default:
                    begin
                        scan_stop = 1'b1;
                    end
                endcase
            end
            else if (!chk_pend_reg && scan_done)
            begin
                // walk finished without a deciding slot
                scan_stop = 1'b1;
                case (op_reg)
                    OP_MAP:
                    begin
                        out_load = 1'b1;
                        status_n = ST_FULL;
                    end
                    OP_UNMAP,
                    OP_VIRT_TO_PHYS,
                    OP_PHYS_TO_VIRT:
                    begin
                        out_load = 1'b1;
                        status_n = ST_NOT_FOUND;
                    end
                    OP_IS_MAPPED:
                    begin
                        out_load = 1'b1;
                    end
                    default:
                    begin
                        out_load = 1'b0;
                    end
                endcase
            end
        end
        else if (state_reg == S_FIN && adv)
        begin
            out_load = 1'b1;
            hit_n    = 1'b1;
            addr_n   = base_reg + off_reg;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_acc && op_known)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_stop)
                begin
                    state_next = cap_fin ? S_FIN : S_IDLE;
                end
            end
            S_FIN:
            begin
                if (adv)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_idx_reg    <= '0;
            chk_pend_reg  <= 1'b0;
            chk_valid_reg <= 1'b0;
            chk_idx_reg   <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (req_acc)
            begin
                rd_idx_reg   <= '0;
                chk_pend_reg <= 1'b0;
            end
            else if (state_reg == S_SCAN && adv)
            begin
                chk_pend_reg <= rd_en;
                if (rd_en)
                begin
                    rd_idx_reg    <= rd_idx_reg + CNT_W'(1);
                    chk_valid_reg <= valid_reg[rd_idx_reg[IDX_W-1:0]];
                    chk_idx_reg   <= rd_idx_reg[IDX_W-1:0];
                end
            end
            if (set_v)
            begin
                valid_reg[chk_idx_reg] <= 1'b1;
            end
            else if (clr_v)
            begin
                valid_reg[chk_idx_reg] <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // request, add stage and result payload
    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            op_reg  <= op_t'(req.operation);
            va_reg  <= req.virt_addr;
            pa_reg  <= req.phys_addr;
            len_reg <= req.length;
        end
        if (cap_fin)
        begin
            base_reg <= other_base;
            off_reg  <= dsub[ADDR_BITS-1:0];
        end
        if (out_load)
        begin
            status_reg     <= status_n;
            addr_out_reg   <= addr_n;
            length_out_reg <= len_n;
            hit_reg        <= hit_n;
            last_reg       <= last_n;
        end
    end

    // entry memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[chk_idx_reg] <= '{virt: va_reg, phys: pa_reg, len: len_reg};
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_idx_reg[IDX_W-1:0]];
        end
    end

    // result channel
    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = status_reg;
    assign rsp.addr_out   = addr_out_reg;
    assign rsp.length_out = length_out_reg;
    assign rsp.hit        = hit_reg;
    assign rsp.last       = last_reg;

    // map only ever fills a free slot
    a_map_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> !valid_reg[chk_idx_reg])
        else $error("map wrote a slot that was in use");

    // the result register is never overwritten while still held
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || rsp.ready))
        else $error("result register overwritten before it was taken");

    // the final unmap-all result leaves an empty table
    a_unmap_all_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && op_reg == OP_UNMAP_ALL && last_n) |=> (valid_reg == '0))
        else $error("table not empty after last unmap-all result");

    // the walk never runs past the last slot
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rd_idx_reg <= CNT_W'(ENTRIES))
        else $error("scan index beyond table");

    // a translation add stage only follows a containing hit
    a_fin_from_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && !$past(state_reg == S_FIN)) |->
        $past(cap_fin && chk_valid_reg && in_range))
        else $error("add stage entered without a containing region");

endmodule

// ----- verif/irt_checker.sv -----
// result checker of the io region translation table: table prediction and field compare
module irt_checker (
    input  logic        clk,
    input  logic        rst_n,
    irt_req_if          req,
    irt_rsp_if          rsp,
    output int unsigned mismatch_count,
    output int unsigned results_due
);
    import irt_pkg::*;

    typedef struct packed {
        status_t              status;
        logic [ADDR_BITS-1:0] addr;
        logic [LEN_BITS-1:0]  len;
        logic                 hit;
        logic                 last;
    } result_t;

    // predicted copy of the region table
    logic                 slot_used [ENTRIES];
    logic [ADDR_BITS-1:0] slot_virt [ENTRIES];
    logic [ADDR_BITS-1:0] slot_phys [ENTRIES];
    logic [LEN_BITS-1:0]  slot_len  [ENTRIES];

    result_t     awaited_results [$];
    int unsigned mismatches;

    function automatic void clear_table();
        for (int i = 0; i < ENTRIES; i++)
        begin
            slot_used[i] = 1'b0;
            slot_virt[i] = '0;
            slot_phys[i] = '0;
            slot_len[i]  = '0;
        end
    endfunction

    function automatic void push_result(status_t st, logic [ADDR_BITS-1:0] addr,
                                        logic [LEN_BITS-1:0] len, logic hit, logic last);
        result_t r;
        r.status = st;
        r.addr   = addr;
        r.len    = len;
        r.hit    = hit;
        r.last   = last;
        awaited_results.push_back(r);
    endfunction

    // lowest valid region that holds addr, by virtual or physical base
    function automatic int find_region(logic [ADDR_BITS-1:0] addr, logic by_phys);
        logic [ADDR_BITS-1:0] base;
        for (int i = 0; i < ENTRIES; i++)
        begin
            base = by_phys ? slot_phys[i] : slot_virt[i];
            if (slot_used[i] && addr >= base && (addr - base) < slot_len[i])
                return i;
        end
        return -1;
    endfunction

    // apply one accepted request to the table copy and queue its results
    task automatic apply_request(input logic [OP_W-1:0] op, input logic [ADDR_BITS-1:0] va,
                                 input logic [ADDR_BITS-1:0] pa, input logic [LEN_BITS-1:0] len);
        int                   slot;
        int                   total;
        int                   seen;
        logic [ADDR_BITS-1:0] moved;
        begin
            slot  = -1;
            total = 0;
            seen  = 0;
            case (op)
                OP_MAP:
                begin
                    for (int i = ENTRIES - 1; i >= 0; i--)
                        if (!slot_used[i])
                            slot = i;
                    // fullness wins over a null base
                    if (slot < 0)
                        push_result(ST_FULL, '0, '0, 1'b0, 1'b1);
                    else if (va == '0)
                        push_result(ST_NULL_BASE, '0, '0, 1'b0, 1'b1);
                    else
                    begin
                        slot_used[slot] = 1'b1;
                        slot_virt[slot] = va;
                        slot_phys[slot] = pa;
                        slot_len[slot]  = len;
                        push_result(ST_OK, va, '0, 1'b0, 1'b1);
                    end
                end
                OP_UNMAP:
                begin
                    for (int i = ENTRIES - 1; i >= 0; i--)
                        if (slot_used[i] && slot_virt[i] == va)
                            slot = i;
                    if (slot < 0)
                        push_result(ST_NOT_FOUND, '0, '0, 1'b0, 1'b1);
                    else
                    begin
                        push_result(ST_OK, slot_virt[slot], slot_len[slot], 1'b0, 1'b1);
                        slot_used[slot] = 1'b0;
                        slot_virt[slot] = '0;
                        slot_phys[slot] = '0;
                        slot_len[slot]  = '0;
                    end
                end
                OP_VIRT_TO_PHYS:
                begin
                    slot = find_region(va, 1'b0);
                    if (slot < 0)
                        push_result(ST_NOT_FOUND, '0, '0, 1'b0, 1'b1);
                    else
                    begin
                        moved = slot_phys[slot] + (va - slot_virt[slot]);
                        push_result(ST_OK, moved, '0, 1'b1, 1'b1);
                    end
                end
                OP_PHYS_TO_VIRT:
                begin
                    slot = find_region(pa, 1'b1);
                    if (slot < 0)
                        push_result(ST_NOT_FOUND, '0, '0, 1'b0, 1'b1);
                    else
                    begin
                        moved = slot_virt[slot] + (pa - slot_phys[slot]);
                        push_result(ST_OK, moved, '0, 1'b1, 1'b1);
                    end
                end
                OP_IS_MAPPED:
                    push_result(ST_OK, '0, '0, find_region(pa, 1'b1) >= 0, 1'b1);
                OP_UNMAP_ALL:
                begin
                    // one release per valid slot in slot order, last flag on the final one
                    for (int i = 0; i < ENTRIES; i++)
                        if (slot_used[i])
                            total++;
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (slot_used[i])
                        begin
                            seen++;
                            push_result(ST_OK, slot_virt[i], slot_len[i], 1'b0, seen == total);
                        end
                    end
                    clear_table();
                end
                default:
                    ;
            endcase
        end
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        begin
            if (want !== got)
            begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
            end
        end
    endtask

    // compare results first, then predict the request of this edge
    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        if (!rst_n)
        begin
            clear_table();
            awaited_results.delete();
            mismatches = 0;
            mismatch_count <= 0;
            results_due    <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result with none expected, expected none, %s %0h %0h %0h %0b %0b",
                             $time, "actual", rsp.status, rsp.addr_out,
                             rsp.length_out, rsp.hit, rsp.last);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    compare_field("status", 64'(want.status), 64'(rsp.status));
                    compare_field("addr_out", 64'(want.addr), 64'(rsp.addr_out));
                    compare_field("length_out", 64'(want.len), 64'(rsp.length_out));
                    compare_field("hit", 64'(want.hit), 64'(rsp.hit));
                    compare_field("last", 64'(want.last), 64'(rsp.last));
                end
            end
            if (req.valid && req.ready)
                apply_request(req.operation, req.virt_addr, req.phys_addr, req.length);
            mismatch_count <= mismatches;
            results_due    <= awaited_results.size();
        end
    end

endmodule

// ----- verif/testbench.sv -----
// testbench top of the io region translation table: clock, reset, request stimulus and verdict
module testbench;
    import irt_pkg::*;

    localparam int RANDOM_ITEMS  = 410;
    localparam int CALM_ITEMS    = 60;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = ENTRIES + 16;

    // codes outside the operation set, dropped by the block
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    typedef struct {
        logic [ADDR_BITS-1:0] virt;
        logic [ADDR_BITS-1:0] phys;
        logic [LEN_BITS-1:0]  len;
    } region_t;

    logic        clk;
    logic        rst_n;
    int unsigned mismatch_count;
    int unsigned results_due;

    logic        src_idle;
    logic        snk_idle;
    logic        hold_sink;
    int          sent;
    region_t     mapped_q [$];

    irt_req_if req ();
    irt_rsp_if rsp ();

    io_region_translation_table u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    irt_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req),
        .rsp            (rsp),
        .mismatch_count (mismatch_count),
        .results_due    (results_due)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // run limit
    initial
    begin : watchdog
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [ADDR_BITS-1:0] rand_addr();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[ADDR_BITS-1:0];
    endfunction

    // base address: mostly a small window so that regions overlap
    function automatic logic [ADDR_BITS-1:0] pick_base();
        int unsigned          sel;
        logic [ADDR_BITS-1:0] b;
        sel = $urandom_range(0, 99);
        b   = ADDR_BITS'($urandom_range(1, 255));
        if (sel < 5)
            return '0;
        if (sel < 10)
            return '1;
        if (sel < 25)
            return rand_addr();
        return b << 12;
    endfunction

    function automatic logic [LEN_BITS-1:0] pick_len();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 5)
            return '0;
        if (sel < 10)
            return '1;
        if (sel < 25)
            return $urandom;
        return $urandom_range(1, 16'h3000);
    endfunction

    // address at, inside or just outside a region
    function automatic logic [ADDR_BITS-1:0] pick_near(logic [ADDR_BITS-1:0] base,
                                                       logic [LEN_BITS-1:0] len);
        logic [ADDR_BITS-1:0] span;
        span = ADDR_BITS'(len);
        case ($urandom_range(0, 5))
            0:       return base;
            1:       return base + span - 1;
            2:       return base + span;
            3:       return base - 1;
            default: return (len == '0) ? base : base + ($urandom % len);
        endcase
    endfunction

    // offer one request and hold it until accepted; valid stays high on return
    task automatic send_req(input logic [OP_W-1:0] op, input logic [ADDR_BITS-1:0] va,
                            input logic [ADDR_BITS-1:0] pa, input logic [LEN_BITS-1:0] len);
        begin
            if (sent >= RANDOM_ITEMS - CALM_ITEMS)
            begin
                src_idle = 1'b0;
                snk_idle = 1'b0;
            end
            if (src_idle && $urandom_range(0, 2) == 0)
            begin
                req.valid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            req.valid     <= 1'b1;
            req.operation <= op;
            req.virt_addr <= va;
            req.phys_addr <= pa;
            req.length    <= len;
            @(posedge clk);
            while (!req.ready)
                @(posedge clk);
            // rough list of live regions, used only to aim addresses
            case (op)
                OP_MAP:
                    if (va != '0 && mapped_q.size() < ENTRIES)
                        mapped_q.push_back('{va, pa, len});
                OP_UNMAP:
                    for (int i = 0; i < mapped_q.size(); i++)
                    begin
                        if (mapped_q[i].virt == va)
                        begin
                            mapped_q.delete(i);
                            break;
                        end
                    end
                OP_UNMAP_ALL:
                    mapped_q.delete();
                default:
                    ;
            endcase
            if (op != OP_SPARE_LO && op != OP_SPARE_HI)
                sent++;
        end
    endtask

    // sender pause until every predicted result has come back
    task automatic wait_drain();
        begin
            req.valid <= 1'b0;
            @(posedge clk);
            while (results_due != 0)
                @(posedge clk);
        end
    endtask

    // one request of random kind, partly aimed at live regions
    task automatic send_random();
        int unsigned          sel;
        region_t              r;
        logic [ADDR_BITS-1:0] va;
        logic [ADDR_BITS-1:0] pa;
        logic [LEN_BITS-1:0]  len;
        begin
            sel = $urandom_range(0, 99);
            va  = (sel[1]) ? pick_base() : rand_addr();
            pa  = (sel[2]) ? pick_base() : rand_addr();
            len = pick_len();
            if (mapped_q.size() > 0)
                r = mapped_q[$urandom_range(0, mapped_q.size() - 1)];
            else
                r = '{pick_base(), pick_base(), pick_len()};
            if (sel < 30)
                send_req(OP_MAP, pick_base(), pick_base(), len);
            else if (sel < 36)
                send_req(OP_MAP, r.virt, pa, len);
            else if (sel < 46)
                send_req(OP_UNMAP, r.virt, pa, len);
            else if (sel < 50)
                send_req(OP_UNMAP, va, pa, len);
            else if (sel < 64)
                send_req(OP_VIRT_TO_PHYS, pick_near(r.virt, r.len), pa, len);
            else if (sel < 70)
                send_req(OP_VIRT_TO_PHYS, va, pa, len);
            else if (sel < 82)
                send_req(OP_PHYS_TO_VIRT, va, pick_near(r.phys, r.len), len);
            else if (sel < 86)
                send_req(OP_PHYS_TO_VIRT, va, pa, len);
            else if (sel < 95)
                send_req(OP_IS_MAPPED, va, sel[0] ? pick_near(r.phys, r.len) : pa, len);
            else if (sel < 97)
                send_req(OP_UNMAP_ALL, va, pa, len);
            else
                send_req(sel[0] ? OP_SPARE_LO : OP_SPARE_HI, va, pa, len);
        end
    endtask

    // map until every slot is taken, then map into the full table
    task automatic fill_table();
        begin
            while (mapped_q.size() < ENTRIES)
                send_req(OP_MAP, pick_base(), pick_base(), pick_len());
            send_req(OP_MAP, '0, rand_addr(), $urandom);
            send_req(OP_MAP, pick_base(), pick_base(), pick_len());
        end
    endtask

    // result side: random stalls and one long hold-off on request
    initial
    begin : result_sink
        rsp.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_sink)
            begin
                hold_sink = 1'b0;
                rsp.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (snk_idle && $urandom_range(0, 3) == 0)
            begin
                rsp.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            else
            begin
                rsp.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // request side and verdict
    initial
    begin : stimulus
        int   kind;
        logic opening;
        rst_n         <= 1'b0;
        req.valid     <= 1'b0;
        req.operation <= OP_MAP;
        req.virt_addr <= '0;
        req.phys_addr <= '0;
        req.length    <= '0;
        src_idle  = 1'b1;
        snk_idle  = 1'b1;
        hold_sink = 1'b0;
        sent      = 0;
        opening   = 1'b1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table
        send_req(OP_UNMAP_ALL, '0, '0, '0);
        send_req(OP_VIRT_TO_PHYS, '1, '1, '1);
        send_req(OP_UNMAP, '1, '0, '0);
        send_req(OP_IS_MAPPED, '0, '0, '0);
        send_req(OP_MAP, '0, '1, '1);
        // widest region with phys base at the top, so translations wrap
        send_req(OP_MAP, 48'h1, '1, '1);
        send_req(OP_MAP, '1, '0, 32'h1);
        send_req(OP_MAP, 48'h1000, 48'h2000, '0);
        send_req(OP_MAP, 48'h1000, 48'h9000, 32'h100);
        send_req(OP_VIRT_TO_PHYS, 48'h1000, '0, '0);
        send_req(OP_VIRT_TO_PHYS, 48'hFFFF_FFFF, '0, '0);
        send_req(OP_VIRT_TO_PHYS, 48'h1_0000_0000, '0, '0);
        send_req(OP_VIRT_TO_PHYS, '1, '0, '0);
        send_req(OP_PHYS_TO_VIRT, '0, '0, '0);
        send_req(OP_PHYS_TO_VIRT, '0, 48'h1, '0);
        send_req(OP_IS_MAPPED, '0, 48'h90FF, '0);
        send_req(OP_IS_MAPPED, '0, 48'h9100, '0);
        // zero length slot matches first on exact base
        send_req(OP_UNMAP, 48'h1000, '0, '0);
        send_req(OP_MAP, 48'h5000, 48'h5000, 32'h10);
        send_req(OP_SPARE_LO, '1, '1, '1);
        send_req(OP_SPARE_HI, '1, '1, '1);
        send_req(OP_UNMAP, 48'h4242, '0, '0);
        send_req(OP_UNMAP_ALL, '0, '0, '0);
        send_req(OP_VIRT_TO_PHYS, 48'h5000, '0, '0);
        wait_drain();

        // random segments
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            src_idle = $urandom_range(0, 2) != 0;
            snk_idle = $urandom_range(0, 2) != 0;
            kind     = opening ? 0 : $urandom_range(0, 7);
            if (kind == 0)
            begin
                fill_table();
                if (opening)
                begin
                    // long result hold-off while requests keep coming
                    hold_sink = 1'b1;
                    send_req(OP_UNMAP_ALL, rand_addr(), rand_addr(), $urandom);
                    repeat (8) send_random();
                    wait_drain();
                    opening = 1'b0;
                end
            end
            else if (kind == 1)
                send_req(OP_UNMAP_ALL, rand_addr(), rand_addr(), $urandom);
            else
                repeat ($urandom_range(10, 40)) send_random();
            if ($urandom_range(0, 3) == 0)
                wait_drain();
        end

        // drain and verdict
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && results_due == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
